FILE: rtl/ps2mc_pkg.sv
// Shared types and constants for the PS/2 mouse cursor tracker.
// No dependencies; every other rtl file refers to it by scoped names.
package ps2mc_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CoordWidth = 12;
   localparam int unsigned RspWidth   = 32;

   localparam logic [ByteWidth-1:0]  SYNC_MASK  = 8'h08;
   localparam logic [ByteWidth-1:0]  LEFT_MASK  = 8'h01;
   localparam logic [CoordWidth-1:0] X_LIMIT_RESET = 12'd1014;
   localparam logic [CoordWidth-1:0] Y_LIMIT_RESET = 12'd758;
   localparam logic [CoordWidth-1:0] POS_X_RESET   = 12'd512;
   localparam logic [CoordWidth-1:0] POS_Y_RESET   = 12'd384;

   // Position of the next byte within a three-byte packet
   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_XDELTA = 2'd1,
      PHASE_YDELTA = 2'd2
   } phase_type;

   // Configuration register indexes
   typedef enum logic {
      REG_X_LIMIT = 1'b0,
      REG_Y_LIMIT = 1'b1
   } reg_index_type;

   // Completed packet, handed from the framer to the motion unit
   typedef struct packed {
      logic                 complete;
      logic [ByteWidth-1:0] header;
      logic [ByteWidth-1:0] dx;
      logic [ByteWidth-1:0] dy;
   } packet_type;

   // One result item
   typedef struct packed {
      logic                  release_edge;
      logic                  press_edge;
      logic [CoordWidth-1:0] cursor_y;
      logic [CoordWidth-1:0] cursor_x;
   } result_type;

endpackage

FILE: rtl/ps2mc_framer.sv
// Packet framer: aligns raw mouse bytes into three-byte packets.
// Depends on ps2mc_pkg.
module ps2mc_framer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            byte_valid,
   input  logic [ps2mc_pkg::ByteWidth-1:0] byte_data,
   output logic                            last_byte,
   output ps2mc_pkg::packet_type           pkt
);

   ps2mc_pkg::phase_type             phase_ff, phase_in;
   logic [ps2mc_pkg::ByteWidth-1:0]  header_ff, header_in;
   logic [ps2mc_pkg::ByteWidth-1:0]  dx_ff, dx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ps2mc_pkg::PHASE_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
      header_ff <= header_in;
      dx_ff     <= dx_in;
   end

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      dx_in     = dx_ff;
      last_byte = 1'b0;
      unique case (phase_ff)
         ps2mc_pkg::PHASE_XDELTA: begin
            if (byte_valid) begin
               dx_in    = byte_data;
               phase_in = ps2mc_pkg::PHASE_YDELTA;
            end
         end
         ps2mc_pkg::PHASE_YDELTA: begin
            last_byte = 1'b1;
            if (byte_valid) begin
               phase_in = ps2mc_pkg::PHASE_HEADER;
            end
         end
         default: begin
            // drop a header candidate without the sync bit
            if (byte_valid) begin
               header_in = byte_data;
               phase_in  = ((byte_data & ps2mc_pkg::SYNC_MASK) != '0) ?
                           ps2mc_pkg::PHASE_XDELTA : ps2mc_pkg::PHASE_HEADER;
            end
         end
      endcase
   end

   assign pkt.complete = byte_valid && last_byte;
   assign pkt.header   = header_ff;
   assign pkt.dx       = dx_ff;
   assign pkt.dy       = byte_data;

endmodule

FILE: rtl/ps2mc_motion.sv
// Motion unit: limit registers, cursor position, left-button edge detect.
// Depends on ps2mc_pkg.
module ps2mc_motion (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  ps2mc_pkg::reg_index_type         csr_addr,
   input  logic [ps2mc_pkg::CoordWidth-1:0] csr_wdata,
   input  ps2mc_pkg::packet_type            pkt,
   output ps2mc_pkg::result_type            result
);

   localparam int unsigned SumWidth = ps2mc_pkg::CoordWidth + 2;

   logic [ps2mc_pkg::CoordWidth-1:0] x_limit_ff, x_limit_in;
   logic [ps2mc_pkg::CoordWidth-1:0] y_limit_ff, y_limit_in;
   logic [ps2mc_pkg::CoordWidth-1:0] pos_x_ff, pos_x_in;
   logic [ps2mc_pkg::CoordWidth-1:0] pos_y_ff, pos_y_in;
   logic                             left_held_ff, left_held_in;

   logic signed [SumWidth-1:0]       sum_x;
   logic signed [SumWidth-1:0]       sum_y;
   logic                             down;

   function automatic logic [ps2mc_pkg::CoordWidth-1:0] clamp_coord(
      input logic signed [SumWidth-1:0]       v,
      input logic [ps2mc_pkg::CoordWidth-1:0] lim
   );
      logic [ps2mc_pkg::CoordWidth-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v[SumWidth-2:0] > {1'b0, lim}) begin
         r = lim;
      end else begin
         r = v[ps2mc_pkg::CoordWidth-1:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff   <= ps2mc_pkg::X_LIMIT_RESET;
         y_limit_ff   <= ps2mc_pkg::Y_LIMIT_RESET;
         pos_x_ff     <= ps2mc_pkg::POS_X_RESET;
         pos_y_ff     <= ps2mc_pkg::POS_Y_RESET;
         left_held_ff <= 1'b0;
      end else begin
         x_limit_ff   <= x_limit_in;
         y_limit_ff   <= y_limit_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         left_held_ff <= left_held_in;
      end
   end

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_we) begin
         unique case (csr_addr)
            ps2mc_pkg::REG_X_LIMIT: x_limit_in = csr_wdata;
            ps2mc_pkg::REG_Y_LIMIT: y_limit_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      down  = (pkt.header & ps2mc_pkg::LEFT_MASK) != '0;
      sum_x = signed'({2'b00, pos_x_ff}) + SumWidth'(signed'(pkt.dx));
      sum_y = signed'({2'b00, pos_y_ff}) - SumWidth'(signed'(pkt.dy));

      result.cursor_x     = clamp_coord(sum_x, x_limit_ff);
      result.cursor_y     = clamp_coord(sum_y, y_limit_ff);
      result.press_edge   = down && !left_held_ff;
      result.release_edge = !down && left_held_ff;

      // advance position and button state only when a packet closes
      pos_x_in     = pkt.complete ? result.cursor_x : pos_x_ff;
      pos_y_in     = pkt.complete ? result.cursor_y : pos_y_ff;
      left_held_in = pkt.complete ? down : left_held_ff;
   end

endmodule

FILE: rtl/ps2mc_out_reg.sv
// Result register: holds one result item until the consumer takes it.
// Depends on ps2mc_pkg.
module ps2mc_out_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  ps2mc_pkg::result_type          result,
   output logic                           slot_free,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ps2mc_pkg::RspWidth-1:0] rsp_tdata
);

   localparam int unsigned ResultBits = $bits(ps2mc_pkg::result_type);

   logic                  valid_ff, valid_in;
   ps2mc_pkg::result_type data_ff, data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   // free when empty or draining this cycle
   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(ps2mc_pkg::RspWidth - ResultBits){1'b0}}, data_ff};

endmodule

FILE: rtl/ps2_mouse_cursor_tracker.sv
// Top level of the PS/2 mouse cursor tracker.
// Depends on ps2mc_pkg, ps2mc_framer, ps2mc_motion and ps2mc_out_reg.
//
//   channel  direction  handshake          payload
//   req_     in         tvalid/tready      tdata[7:0] data_byte
//   rsp_     out        tvalid/tready      tdata: cursor_x, cursor_y, press, release
//   csr_     in         we (no handshake)  addr selects x_limit/y_limit, wdata 12 bits
//
// One byte is taken per cycle unless a third byte waits (see below); the third
// byte of a packet produces its result in the rsp register on the next cycle.
// Header and x-delta bytes are accepted even while the rsp register is full;
// a third byte waits until the rsp register is empty or being drained.
// Synchronous reset clears phase and rsp valid, presets positions and limits.
module ps2_mouse_cursor_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ps2mc_pkg::ByteWidth-1:0]  req_tdata,  // [7:0] data_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [11:0] cursor_x, [23:12] cursor_y, [24] press_edge, [25] release_edge, rest zero
   output logic [ps2mc_pkg::RspWidth-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  ps2mc_pkg::reg_index_type         csr_addr,
   input  logic [ps2mc_pkg::CoordWidth-1:0] csr_wdata
);

   logic                  last_byte;
   logic                  slot_free;
   logic                  req_accept;
   ps2mc_pkg::packet_type pkt;
   ps2mc_pkg::result_type result;

   assign req_tready = !last_byte || slot_free;
   assign req_accept = req_tvalid && req_tready;

   ps2mc_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_accept),
      .byte_data  (req_tdata),
      .last_byte  (last_byte),
      .pkt        (pkt)
   );

   ps2mc_motion u_motion (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .pkt       (pkt),
      .result    (result)
   );

   ps2mc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (pkt.complete),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/ps2mc_checker.sv
// Port-level checks for the PS/2 mouse cursor tracker, bound to the top level.
// Depends on ps2mc_pkg and ps2_mouse_cursor_tracker.
module ps2mc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ps2mc_pkg::RspWidth-1:0]  rsp_tdata
);

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a press and a release never come together
   a_edge_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[24] && rsp_tdata[25]))
      else $error("press and release both set");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:26] == 6'd0)
      else $error("nonzero padding in rsp_tdata");

   // an empty result register never stalls the input
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

bind ps2_mouse_cursor_tracker ps2mc_checker u_ps2mc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/tb_top.sv
// Testbench for ps2_mouse_cursor_tracker: drives PS/2 bytes, tracks cursor moves in a
// local copy of the packet parser and checks every result item field by field.
// Depends on ps2mc_pkg and the RTL of the block only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2mc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ByteWidth-1:0]  req_tdata;   // [7:0] data_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [11:0] cursor_x, [23:12] cursor_y, [24] press_edge, [25] release_edge
   logic [RspWidth-1:0]   rsp_tdata;
   logic                  csr_we;
   reg_index_type         csr_addr;
   logic [CoordWidth-1:0] csr_wdata;

   ps2_mouse_cursor_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the parser state
   phase_type             trk_phase;
   logic [ByteWidth-1:0]  trk_header;
   logic [ByteWidth-1:0]  trk_dx;
   logic [CoordWidth-1:0] trk_x;
   logic [CoordWidth-1:0] trk_y;
   logic                  trk_left;
   logic [CoordWidth-1:0] trk_x_limit;
   logic [CoordWidth-1:0] trk_y_limit;

   result_type expected_moves[$];

   int error_count = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   bit gapless     = 1'b0;
   bit hold_request = 1'b0;
   int hold_cycles  = 0;

   function automatic logic [CoordWidth-1:0] limit_coord(int v, logic [CoordWidth-1:0] lim);
      if (v < 0)
         return '0;
      if (v > int'(lim))
         return lim;
      return v[CoordWidth-1:0];
   endfunction

   // Advance the local parser by one accepted byte
   function automatic void track_byte(logic [ByteWidth-1:0] b);
      int dx;
      int dy;
      logic down;
      result_type move;
      case (trk_phase)
         PHASE_XDELTA: begin
            trk_dx    = b;
            trk_phase = PHASE_YDELTA;
         end
         PHASE_YDELTA: begin
            down = (trk_header & LEFT_MASK) != 0;
            dx = int'($signed(trk_dx));
            dy = int'($signed(b));
            move.press_edge   = down && !trk_left;
            move.release_edge = !down && trk_left;
            trk_left = down;
            trk_x = limit_coord(int'(trk_x) + dx, trk_x_limit);
            trk_y = limit_coord(int'(trk_y) - dy, trk_y_limit);
            move.cursor_x = trk_x;
            move.cursor_y = trk_y;
            expected_moves.push_back(move);
            trk_phase = PHASE_HEADER;
         end
         default: begin
            trk_header = b;
            trk_phase  = ((b & SYNC_MASK) != 0) ? PHASE_XDELTA : PHASE_HEADER;
         end
      endcase
   endfunction

   // Check results first, then track inputs accepted at the same edge
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (expected_moves.size() == 0) begin
               $error("unexpected result item: cursor_x %0d cursor_y %0d",
                      got.cursor_x, got.cursor_y);
               error_count++;
            end else begin
               want = expected_moves.pop_front();
               if (got.cursor_x !== want.cursor_x) begin
                  $error("cursor_x: expected %0d, actual %0d", want.cursor_x, got.cursor_x);
                  error_count++;
               end
               if (got.cursor_y !== want.cursor_y) begin
                  $error("cursor_y: expected %0d, actual %0d", want.cursor_y, got.cursor_y);
                  error_count++;
               end
               if (got.press_edge !== want.press_edge) begin
                  $error("press_edge: expected %0b, actual %0b",
                         want.press_edge, got.press_edge);
                  error_count++;
               end
               if (got.release_edge !== want.release_edge) begin
                  $error("release_edge: expected %0b, actual %0b",
                         want.release_edge, got.release_edge);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            track_byte(req_tdata);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Receiver: stretches of steady, patterned or sparse ready, plus requested hold-offs
   initial begin
      int       stretch_left;
      int       mode;
      int       pat_idx;
      logic [7:0] pattern;
      rsp_tready   = 1'b0;
      stretch_left = 0;
      mode         = 0;
      pat_idx      = 0;
      pattern      = 8'hFF;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles  = 300;
         end
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(20, 200);
               mode         = $urandom_range(0, 2);
               pattern      = 8'($urandom_range(1, 255));
            end
            stretch_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: begin
                  rsp_tready <= pattern[pat_idx[2:0]];
                  pat_idx++;
               end
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_byte(input logic [ByteWidth-1:0] b);
      int gap;
      int r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         r = $urandom_range(0, 9);
         gap = (gapless || r < 4) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 30);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold the sender until every expected move has arrived
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_limit(input reg_index_type idx, input logic [CoordWidth-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      if (idx == REG_X_LIMIT)
         trk_x_limit = val;
      else
         trk_y_limit = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [ByteWidth-1:0] pick_delta(int drift);
      case ($urandom_range(0, 7))
         0: return 8'h7F;
         1: return 8'h80;
         2: return 8'h00;
         3, 4: begin
            if (drift > 0)
               return 8'($urandom_range(64, 127));
            if (drift < 0)
               return 8'($urandom_range(128, 192));
            return 8'($urandom_range(0, 255));
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Misaligned headers, edge deltas, every header bit and both button edges
   task automatic test_directed_packets();
      logic [ByteWidth-1:0] seq [20] = '{
         8'h00, 8'hF7,
         8'h09, 8'h7F, 8'h80,
         8'h08, 8'h80, 8'h7F,
         8'hFF, 8'h00, 8'h00,
         8'h39, 8'h01, 8'hFF,
         8'h08, 8'hFF, 8'h01,
         8'h08, 8'h00, 8'h00
      };
      foreach (seq[i])
         send_byte(seq[i]);
      wait_idle();
   endtask

   // Position above a freshly lowered limit is clamped on the next packet
   task automatic test_lowered_limit();
      write_limit(REG_X_LIMIT, 12'd100);
      write_limit(REG_Y_LIMIT, 12'd50);
      send_byte(8'h08);
      send_byte(8'h00);
      send_byte(8'h00);
      wait_idle();
      write_limit(REG_X_LIMIT, 12'd0);
      write_limit(REG_Y_LIMIT, 12'd0);
      send_byte(8'h09);
      send_byte(8'h80);
      send_byte(8'h7F);
      wait_idle();
   endtask

   // Long receiver hold-off while the sender keeps offering packets
   task automatic test_backpressure();
      write_limit(REG_X_LIMIT, X_LIMIT_RESET);
      write_limit(REG_Y_LIMIT, Y_LIMIT_RESET);
      gapless      = 1'b1;
      hold_request = 1'b1;
      repeat (20) begin
         send_byte(8'($urandom_range(0, 255)) | SYNC_MASK);
         send_byte(8'($urandom_range(0, 255)));
         send_byte(8'($urandom_range(0, 255)));
      end
      gapless = 1'b0;
      wait_idle();
   endtask

   // Mostly well-formed packets with drifting deltas, some stray bytes
   task automatic test_random_phase(input logic [CoordWidth-1:0] xl,
                                    input logic [CoordWidth-1:0] yl, input int n_items);
      int sent;
      int drift_x;
      int drift_y;
      logic [ByteWidth-1:0] b;
      write_limit(REG_X_LIMIT, xl);
      write_limit(REG_Y_LIMIT, yl);
      drift_x = int'($urandom_range(0, 2)) - 1;
      drift_y = int'($urandom_range(0, 2)) - 1;
      gapless = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            send_byte(8'($urandom_range(0, 255)) | SYNC_MASK);
            send_byte(pick_delta(drift_x));
            send_byte(pick_delta(drift_y));
            sent += 3;
         end else begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
               b = b & ~SYNC_MASK;
            send_byte(b);
            sent++;
         end
      end
      gapless = 1'b0;
      wait_idle();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = REG_X_LIMIT;
      csr_wdata  = '0;
      trk_phase   = PHASE_HEADER;
      trk_header  = '0;
      trk_dx      = '0;
      trk_x       = POS_X_RESET;
      trk_y       = POS_Y_RESET;
      trk_left    = 1'b0;
      trk_x_limit = X_LIMIT_RESET;
      trk_y_limit = Y_LIMIT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_packets();
      test_lowered_limit();
      test_backpressure();
      test_random_phase(12'd4095, 12'd4095, 240);
      test_random_phase(12'd0, 12'd0, 200);
      test_random_phase(X_LIMIT_RESET, Y_LIMIT_RESET, 240);
      test_random_phase(12'd4095, 12'd0, 220);
      test_random_phase(12'd0, 12'd4095, 220);
      test_random_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 240);
      test_random_phase(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)), 240);
      test_random_phase(12'd3, 12'd2, 200);

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
